/* hw/rtl/gif_image_descriptor_parser_unit_macros.svh */
// ---------------------------------------------------------------------------
// gif image descriptor parser assertion macros
// shared property wrappers on the block clock and reset
// ---------------------------------------------------------------------------
`ifndef GIF_IMAGE_DESCRIPTOR_PARSER_UNIT_MACROS_SVH
`define GIF_IMAGE_DESCRIPTOR_PARSER_UNIT_MACROS_SVH

// checked only outside reset
`define GIDP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define GIDP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/gidp_pkg.sv */
// ---------------------------------------------------------------------------
// gidp_pkg
// shared types, result kind codes and helpers of the descriptor parser
// ---------------------------------------------------------------------------
package gidp_pkg;

  localparam logic [2:0] KIND_DESC  = 3'd0;
  localparam logic [2:0] KIND_ENTRY = 3'd1;
  localparam logic [2:0] KIND_CODE  = 3'd2;
  localparam logic [2:0] KIND_DATA  = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // raw result record between parser and output stage
  // descriptor: bytes 0..7 high to low, packed byte in [7:0]
  // entry: index in [31:24], rgb in [23:0]; code and data: [7:0]
  typedef struct packed {
    logic [2:0]  kind;
    logic [71:0] data;
    logic        hbf;
  } rec_t;

  function automatic logic [8:0] tbl_size(input logic [7:0] packed_byte);
    logic [8:0] sz;
    if (packed_byte[7]) begin
      sz = 9'(9'd2 << packed_byte[2:0]);
    end else begin
      sz = 9'd0;
    end
    return sz;
  endfunction

endpackage

/* hw/rtl/gidp_front.sv */
// ---------------------------------------------------------------------------
// gidp_front
// byte parser: tracks descriptor, table, code size and sub-block phases
// ---------------------------------------------------------------------------
module gidp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          hbf,
  output logic          push,
  output gidp_pkg::rec_t rec
);
  import gidp_pkg::*;

  typedef enum logic [2:0] {
    PH_DESC  = 3'd0,
    PH_TABLE = 3'd1,
    PH_CODE  = 3'd2,
    PH_COUNT = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [8:0]  entry_count, entry_count_next;
  logic [8:0]  table_size, table_size_next;
  logic [15:0] color_bytes, color_bytes_next;
  logic [7:0]  block_remaining, block_remaining_next;
  logic [7:0]  desc [8];
  logic [3:0]  idx;
  logic        desc_we;
  logic        produce;
  logic [8:0]  ts;

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    entry_count_next     = entry_count;
    table_size_next      = table_size;
    color_bytes_next     = color_bytes;
    block_remaining_next = block_remaining;
    produce              = 1'b0;
    desc_we              = 1'b0;
    rec                  = '0;
    idx                  = (byte_count > 4'd8) ? 4'd0 : byte_count;
    ts                   = tbl_size(in_byte);
    case (phase)
      PH_TABLE: begin
        if (byte_count < 4'd2) begin
          color_bytes_next = {color_bytes[7:0], in_byte};
          byte_count_next  = byte_count + 4'd1;
        end else begin
          produce          = 1'b1;
          rec.kind         = KIND_ENTRY;
          rec.data         = {40'd0, entry_count[7:0], color_bytes, in_byte};
          byte_count_next  = 4'd0;
          color_bytes_next = 16'd0;
          entry_count_next = entry_count + 9'd1;
          if (entry_count_next >= table_size) begin
            phase_next = PH_CODE;
          end
        end
      end
      PH_CODE: begin
        produce    = 1'b1;
        rec.kind   = KIND_CODE;
        rec.data   = {64'd0, in_byte};
        phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        if (in_byte == 8'd0) begin
          produce         = 1'b1;
          rec.kind        = KIND_END;
          phase_next      = PH_DESC;
          byte_count_next = 4'd0;
        end else begin
          block_remaining_next = in_byte;
          phase_next           = PH_DATA;
        end
      end
      PH_DATA: begin
        produce              = 1'b1;
        rec.kind             = KIND_DATA;
        rec.data             = {64'd0, in_byte};
        block_remaining_next = block_remaining - 8'd1;
        if (block_remaining_next == 8'd0) begin
          phase_next = PH_COUNT;
        end
      end
      default: begin
        if (idx < 4'd8) begin
          desc_we         = 1'b1;
          byte_count_next = idx + 4'd1;
          phase_next      = PH_DESC;
        end else begin
          produce          = 1'b1;
          byte_count_next  = 4'd0;
          table_size_next  = ts;
          entry_count_next = 9'd0;
          color_bytes_next = 16'd0;
          rec.kind         = KIND_DESC;
          rec.data         = {desc[0], desc[1], desc[2], desc[3],
                              desc[4], desc[5], desc[6], desc[7], in_byte};
          rec.hbf          = hbf;
          phase_next       = (ts != 9'd0) ? PH_TABLE : PH_CODE;
        end
      end
    endcase
    push = accept && produce;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_DESC;
      byte_count      <= 4'd0;
      entry_count     <= 9'd0;
      table_size      <= 9'd0;
      color_bytes     <= 16'd0;
      block_remaining <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      entry_count     <= entry_count_next;
      table_size      <= table_size_next;
      color_bytes     <= color_bytes_next;
      block_remaining <= block_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && desc_we) begin
      desc[idx[2:0]] <= in_byte;
    end
  end

endmodule

/* hw/rtl/gidp_queue.sv */
// ---------------------------------------------------------------------------
// gidp_queue
// small record fifo between parser and output stage
// ---------------------------------------------------------------------------
`include "gif_image_descriptor_parser_unit_macros.svh"

module gidp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gidp_pkg::rec_t push_rec,
  input  logic           pop,
  output gidp_pkg::rec_t head,
  output logic           full,
  output logic           empty
);
  import gidp_pkg::*;

  rec_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  `GIDP_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
  `GIDP_ASSERT(a_no_pop_empty, pop |-> !empty, "pop from empty queue")
  `GIDP_ASSERT(a_count_up, (push && !pop) |=> count == $past(count) + 1'b1, "count mismatch")
  `GIDP_ASSERT_ALWAYS(a_count_range, rst || count <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

/* hw/rtl/gidp_back.sv */
// ---------------------------------------------------------------------------
// gidp_back
// output stage: decodes queue records into result fields and holds them
// ---------------------------------------------------------------------------
`include "gif_image_descriptor_parser_unit_macros.svh"

module gidp_back (
  input  logic           clk,
  input  logic           rst,
  input  gidp_pkg::rec_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     kind,
  output logic [15:0]    left_pos,
  output logic [15:0]    top_pos,
  output logic [15:0]    image_width,
  output logic [15:0]    image_height,
  output logic           interlaced,
  output logic [8:0]     table_entries,
  output logic [7:0]     entry_index,
  output logic [23:0]    color_rgb,
  output logic [7:0]     value,
  output logic           last
);
  import gidp_pkg::*;

  logic [15:0] d_left, d_top, d_width, d_height;
  logic        d_interlaced, d_last;
  logic [8:0]  d_table;
  logic [7:0]  d_index, d_value;
  logic [23:0] d_rgb;

  function automatic logic [15:0] join16(input logic hi_first, input logic [7:0] first,
                                         input logic [7:0] second);
    return hi_first ? {first, second} : {second, first};
  endfunction

  always_comb begin
    d_left       = '0;
    d_top        = '0;
    d_width      = '0;
    d_height     = '0;
    d_interlaced = 1'b0;
    d_table      = '0;
    d_index      = '0;
    d_rgb        = '0;
    d_value      = '0;
    d_last       = 1'b0;
    case (head.kind)
      KIND_DESC: begin
        d_left       = join16(head.hbf, head.data[71:64], head.data[63:56]);
        d_top        = join16(head.hbf, head.data[55:48], head.data[47:40]);
        d_width      = join16(head.hbf, head.data[39:32], head.data[31:24]);
        d_height     = join16(head.hbf, head.data[23:16], head.data[15:8]);
        d_interlaced = head.data[5];
        d_table      = tbl_size(head.data[7:0]);
      end
      KIND_ENTRY: begin
        d_index = head.data[31:24];
        d_rgb   = head.data[23:0];
      end
      KIND_CODE, KIND_DATA: begin
        d_value = head.data[7:0];
      end
      KIND_END: begin
        d_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign pop = !empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind          <= head.kind;
      left_pos      <= d_left;
      top_pos       <= d_top;
      image_width   <= d_width;
      image_height  <= d_height;
      interlaced    <= d_interlaced;
      table_entries <= d_table;
      entry_index   <= d_index;
      color_rgb     <= d_rgb;
      value         <= d_value;
      last          <= d_last;
    end
  end

  `GIDP_ASSERT(a_kind_legal, out_valid |-> kind <= KIND_END, "illegal result kind")
  `GIDP_ASSERT(a_last_end, out_valid |-> (last == (kind == KIND_END)), "last flag mismatch")
  `GIDP_ASSERT(a_desc_zero, (out_valid && kind != KIND_DESC) |-> (left_pos == 16'd0 && table_entries == 9'd0), "descriptor fields not cleared")
  `GIDP_ASSERT(a_load_valid, pop |=> out_valid, "loaded result not presented")

endmodule

/* hw/rtl/gif_image_descriptor_parser_unit.sv */
// result path: a result is written into the record queue as its byte is accepted, then loaded into the output register
// throughput: one byte per cycle; in_ready drops only when the 4-entry record queue fills
// the parser phase register sets the per-byte step, one state update per byte
// reset: phase returns to the descriptor phase, queue and output stage empty,
// byte order register clears to low byte first
// ---------------------------------------------------------------------------
// gif_image_descriptor_parser_unit
// image descriptor, local color table and data sub-block parser
// ---------------------------------------------------------------------------
module gif_image_descriptor_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [15:0] left_pos,
  output logic [15:0] top_pos,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic        interlaced,
  output logic [8:0]  table_entries,
  output logic [7:0]  entry_index,
  output logic [23:0] color_rgb,
  output logic [7:0]  value,
  output logic        last
);
  import gidp_pkg::*;

  logic high_byte_first;
  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  rec_t push_rec;
  rec_t head;

  assign pready   = 1'b1;
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_byte_first <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      high_byte_first <= pwdata[0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {31'd0, high_byte_first};

  gidp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .hbf     (high_byte_first),
    .push    (push),
    .rec     (push_rec)
  );

  gidp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  gidp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .left_pos      (left_pos),
    .top_pos       (top_pos),
    .image_width   (image_width),
    .image_height  (image_height),
    .interlaced    (interlaced),
    .table_entries (table_entries),
    .entry_index   (entry_index),
    .color_rgb     (color_rgb),
    .value         (value),
    .last          (last)
  );

endmodule

/* sim/gidp_stream_checker.sv */
// ---------------------------------------------------------------------------
// gidp_stream_checker
// watches the byte input, the result output and the register port of the
// descriptor parser, predicts every result from the accepted bytes and the
// current byte order, and compares each result field by field
// ---------------------------------------------------------------------------
module gidp_stream_checker
  import gidp_pkg::*;
#(
  parameter logic [2:0] ORDER_REG_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] left_pos,
  input  logic [15:0] top_pos,
  input  logic [15:0] image_width,
  input  logic [15:0] image_height,
  input  logic        interlaced,
  input  logic [8:0]  table_entries,
  input  logic [7:0]  entry_index,
  input  logic [23:0] color_rgb,
  input  logic [7:0]  value,
  input  logic        last,
  output int          mismatches,
  output int          outstanding,
  output int          images_done,
  output int          entries_done,
  output int          data_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_PALETTE,
    ST_CODE_SIZE,
    ST_BLOCK_LEN,
    ST_BLOCK_DATA
  } parse_stage_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] left_pos;
    logic [15:0] top_pos;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        interlaced;
    logic [8:0]  table_entries;
    logic [7:0]  entry_index;
    logic [23:0] color_rgb;
    logic [7:0]  value;
    logic        last;
  } parse_rec_t;

  parse_rec_t   predicted_records[$];
  parse_stage_t stage;
  logic         high_first;
  logic [3:0]   byte_idx;
  logic [7:0]   header [9];
  logic [8:0]   entry_cnt;
  logic [8:0]   palette_len;
  logic [15:0]  color_acc;
  logic [7:0]   block_left;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    images_done  = 0;
    entries_done = 0;
    data_done    = 0;
  end

  function automatic logic [15:0] pair_bytes(input logic hbf, input logic [7:0] first,
                                             input logic [7:0] second);
    return hbf ? {first, second} : {second, first};
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    parse_rec_t rec;
    logic [7:0] flags;
    rec = '0;
    case (stage)
      ST_PALETTE: begin
        if (byte_idx < 4'd2) begin
          color_acc = {color_acc[7:0], b};
          byte_idx  = byte_idx + 4'd1;
        end else begin
          rec.kind        = KIND_ENTRY;
          rec.entry_index = entry_cnt[7:0];
          rec.color_rgb   = {color_acc, b};
          byte_idx        = 4'd0;
          color_acc       = 16'd0;
          entry_cnt       = entry_cnt + 9'd1;
          if (entry_cnt >= palette_len) stage = ST_CODE_SIZE;
          predicted_records.push_back(rec);
        end
      end
      ST_CODE_SIZE: begin
        rec.kind  = KIND_CODE;
        rec.value = b;
        stage     = ST_BLOCK_LEN;
        predicted_records.push_back(rec);
      end
      ST_BLOCK_LEN: begin
        if (b == 8'd0) begin
          rec.kind = KIND_END;
          rec.last = 1'b1;
          stage    = ST_HEADER;
          byte_idx = 4'd0;
          predicted_records.push_back(rec);
        end else begin
          block_left = b;
          stage      = ST_BLOCK_DATA;
        end
      end
      ST_BLOCK_DATA: begin
        rec.kind   = KIND_DATA;
        rec.value  = b;
        block_left = block_left - 8'd1;
        if (block_left == 8'd0) stage = ST_BLOCK_LEN;
        predicted_records.push_back(rec);
      end
      default: begin
        if (byte_idx > 4'd8) byte_idx = 4'd0;
        header[byte_idx] = b;
        if (byte_idx < 4'd8) begin
          byte_idx = byte_idx + 4'd1;
          stage    = ST_HEADER;
        end else begin
          byte_idx          = 4'd0;
          flags             = header[8];
          palette_len       = flags[7] ? 9'(9'd2 << flags[2:0]) : 9'd0;
          rec.kind          = KIND_DESC;
          rec.left_pos      = pair_bytes(high_first, header[0], header[1]);
          rec.top_pos       = pair_bytes(high_first, header[2], header[3]);
          rec.image_width   = pair_bytes(high_first, header[4], header[5]);
          rec.image_height  = pair_bytes(high_first, header[6], header[7]);
          rec.interlaced    = flags[5];
          rec.table_entries = palette_len;
          entry_cnt         = 9'd0;
          color_acc         = 16'd0;
          stage             = (palette_len != 9'd0) ? ST_PALETTE : ST_CODE_SIZE;
          predicted_records.push_back(rec);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    parse_rec_t rec;
    if (predicted_records.size() == 0) begin
      $error("unexpected result transaction of kind %0d", kind);
      mismatches++;
    end else begin
      rec = predicted_records.pop_front();
      check_field("kind", 32'(rec.kind), 32'(kind));
      check_field("left_pos", 32'(rec.left_pos), 32'(left_pos));
      check_field("top_pos", 32'(rec.top_pos), 32'(top_pos));
      check_field("image_width", 32'(rec.image_width), 32'(image_width));
      check_field("image_height", 32'(rec.image_height), 32'(image_height));
      check_field("interlaced", 32'(rec.interlaced), 32'(interlaced));
      check_field("table_entries", 32'(rec.table_entries), 32'(table_entries));
      check_field("entry_index", 32'(rec.entry_index), 32'(entry_index));
      check_field("color_rgb", 32'(rec.color_rgb), 32'(color_rgb));
      check_field("value", 32'(rec.value), 32'(value));
      check_field("last", 32'(rec.last), 32'(last));
    end
    if (kind == KIND_END) images_done++;
    if (kind == KIND_ENTRY) entries_done++;
    if (kind == KIND_DATA) data_done++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stage       = ST_HEADER;
      high_first  = 1'b0;
      byte_idx    = 4'd0;
      entry_cnt   = 9'd0;
      palette_len = 9'd0;
      color_acc   = 16'd0;
      block_left  = 8'd0;
      foreach (header[i]) header[i] = 8'd0;
      predicted_records.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ORDER_REG_ADDR) begin
        high_first = pwdata[0];
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) parse_byte(in_byte);
    end
    outstanding = predicted_records.size();
  end

endmodule

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// drives byte streams of image descriptors, local color tables and data
// sub-blocks into the descriptor parser under both byte orders, with random
// idle cycles on both sides and a long receiver hold-off; a checker module
// predicts and compares every result
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gidp_pkg::*;

  localparam logic [2:0] ORDER_REG_ADDR = 3'd0;
  localparam logic [2:0] SPARE_REG_ADDR = 3'd4;
  localparam int         RANDOM_BYTES   = 1850;
  localparam int         HOLD_CYCLES    = 120;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [15:0] left_pos;
  logic [15:0] top_pos;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        interlaced;
  logic [8:0]  table_entries;
  logic [7:0]  entry_index;
  logic [23:0] color_rgb;
  logic [7:0]  value;
  logic        last;

  int mismatches;
  int outstanding;
  int images_done;
  int entries_done;
  int data_done;
  int sent_bytes = 0;
  bit calm = 1'b0;
  bit hold_rx = 1'b0;

  gif_image_descriptor_parser_unit dut (.*);

  gidp_stream_checker #(.ORDER_REG_ADDR(ORDER_REG_ADDR)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver side: random back-pressure, one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        hold_rx = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  // one input transaction per call
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // bulky: no color table and one full-length sub-block
  task automatic send_random_image(input bit bulky);
    logic [7:0] flags;
    int         entries;
    int         blocks;
    int         len;
    int         r;
    repeat (8) send_byte(pick_byte());
    flags = 8'($urandom_range(255));
    if ($urandom_range(99) >= 10) begin
      r = $urandom_range(99);
      if (r < 80) flags[2:0] = 3'($urandom_range(2));
      else if (r < 97) flags[2:0] = 3'($urandom_range(5, 3));
      else flags[2:0] = 3'($urandom_range(7, 6));
    end
    if (bulky) flags[7] = 1'b0;
    send_byte(flags);
    entries = flags[7] ? (2 << flags[2:0]) : 0;
    repeat (3 * entries) send_byte(pick_byte());
    send_byte(8'($urandom_range(255)));
    blocks = bulky ? 1 : $urandom_range(4);
    repeat (blocks) begin
      r = $urandom_range(99);
      if (bulky || r >= 95) len = 255;
      else if (r < 80) len = $urandom_range(16, 1);
      else len = $urandom_range(64, 17);
      send_byte(8'(len));
      repeat (len) send_byte(8'($urandom_range(255)));
    end
    send_byte(8'h00);
  endtask

  initial begin
    logic [31:0] order_word;
    int          base;
    int          goal;
    bit          first;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // low byte first, all-ones header, interlaced, no color table
    write_reg(ORDER_REG_ADDR, 32'd0);
    repeat (8) send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h02);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    drain();

    // high byte first, then a write outside the register map that must be ignored
    write_reg(ORDER_REG_ADDR, 32'd1);
    write_reg(SPARE_REG_ADDR, 32'd0);
    for (int i = 1; i <= 8; i++) send_byte(8'(i));
    send_byte(8'h80);
    repeat (3) send_byte(8'hFF);
    repeat (3) send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    drain();

    base = sent_bytes;
    for (int p = 0; p < 4; p++) begin
      order_word    = $urandom();
      order_word[0] = p[0];
      write_reg(ORDER_REG_ADDR, order_word);
      calm  = (p == 1);
      goal  = base + RANDOM_BYTES * (p + 1) / 4;
      first = 1'b1;
      if (p == 2) hold_rx = 1'b1;
      while (sent_bytes < goal) begin
        send_random_image(p == 2 && first);
        first = 1'b0;
      end
      calm = 1'b0;
      drain();
    end

    $display("covered %0d images, %0d palette entries and %0d data bytes from %0d input bytes",
             images_done, entries_done, data_done, sent_bytes);
    $display("both byte orders used, with idle gaps, a calm stretch and a long output stall");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
